FILE: rtl/core/tksc_pkg.sv
// ---------------------------------------------------------------------------
// tksc_pkg: shared types and constants for the top-k select core
// Widths, reset values and the score helper.
// ---------------------------------------------------------------------------
package tksc_pkg;

  localparam int unsigned MaxItemsDefault = 1024;
  localparam int unsigned MaxKDefault     = 64;
  localparam int unsigned DataW           = 32;
  localparam int unsigned TopKW           = 7;
  localparam logic [TopKW-1:0] TopKReset  = 7'd10;

  // APB register map
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegTopK = 3'd0;

  // Stored candidate
  typedef struct packed {
    logic [DataW-1:0] id;
    logic [DataW-1:0] cnt;
    logic [DataW-1:0] err;
  } item_t;

  function automatic logic [DataW-1:0] score_f(input item_t it);
    score_f = (it.cnt > it.err) ? (it.cnt - it.err) : '0;
  endfunction

endpackage

FILE: rtl/core/tksc_if.sv
// ---------------------------------------------------------------------------
// tksc_in_if / tksc_out_if: valid/ready channels
// Candidate input channel and result output channel.
// ---------------------------------------------------------------------------
interface tksc_in_if import tksc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] topic_id;
  logic [DataW-1:0] hit_count;
  logic [DataW-1:0] count_error;
  logic             last_item;
  modport source (output valid, topic_id, hit_count, count_error, last_item, input ready);
  modport sink   (input valid, topic_id, hit_count, count_error, last_item, output ready);
endinterface

interface tksc_out_if import tksc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result_id;
  logic [DataW-1:0] result_count;
  logic             result_last;
  modport source (output valid, result_id, result_count, result_last, input ready);
  modport sink   (input valid, result_id, result_count, result_last, output ready);
endinterface

FILE: rtl/core/tksc_mem.sv
// ---------------------------------------------------------------------------
// tksc_mem: candidate store
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module tksc_mem import tksc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDefault,
  localparam int unsigned AW = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  item_t         wdata,
  input  logic [AW-1:0] raddr,
  output item_t         rdata
);
  item_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/top_k_select_count_minus_error_core.sv
// ---------------------------------------------------------------------------
// top_k_select_count_minus_error_core: top-k selector by count minus error
// Loads candidates, runs quickselect on one store, emits the top items.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : candidate transactions (topic id, count, error, last mark).
//           One transaction per cycle while loading; items past MAX_ITEMS
//           are dropped. The last-marked transaction starts selection.
//   out_* : min(top_k, n, MAX_K) result transactions, last one marked.
//   cfg_* : APB port, top_k at address 0; write it only while idle (not enforced).
// Timing: selection goes through the candidate memory and its registered
//   read port: each partition pass fetches the pivot, scans elements,
//   swaps out-of-place pairs and then picks the next range; the total is
//   data dependent, typically O(n) passes summed.
//   Output: each result is read from the memory into the output register;
//   the next read waits while that register is held by receiver stall.
// Reset: clears the load count, top_k returns to 10; no memory clear.
// Stalls: the result holds in the output register until out_ready.
// ---------------------------------------------------------------------------
module top_k_select_count_minus_error_core import tksc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDefault,
  parameter int unsigned MAX_K     = MaxKDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  tksc_in_if.sink             in_ch,
  tksc_out_if.source          out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = AW + 1;   // count incl. full
  localparam int unsigned SW = CW + 1;   // signed index

  typedef enum logic [4:0] {
    S_LOAD, S_OUTER, S_PIVR, S_PIVW, S_SCAN_I, S_SCAN_IW, S_SCAN_J, S_SCAN_JW,
    S_SWP_RI, S_SWP_RIW, S_SWP_WJ, S_SWP_WI, S_NEXT, S_EMIT_R, S_EMIT_W, S_EMIT_H
  } state_t;

  state_t                 state_r;
  logic [TopKW-1:0]       top_k_r;
  logic [CW-1:0]          cnt_r;
  logic signed [SW-1:0]   lo_r, hi_r, i_r, j_r, tgt_r;
  logic [DataW-1:0]       piv_r;
  logic [CW-1:0]          m_r, r_r;
  item_t                  tmp_r;
  logic                   ov_r;
  logic [DataW-1:0]       oid_r, ocnt_r;
  logic                   olast_r;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  item_t                  wdata, rdata;
  logic [DataW-1:0]       rs;

  tksc_mem #(.MAX_ITEMS(MAX_ITEMS)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rs = score_f(rdata);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegTopK) ? {{(32-TopKW){1'b0}}, top_k_r} : '0;

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = ov_r;
  assign out_ch.result_id   = oid_r;
  assign out_ch.result_count = ocnt_r;
  assign out_ch.result_last = olast_r;

  logic in_acc;
  assign in_acc = in_ch.valid && (state_r == S_LOAD);

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = '{id: in_ch.topic_id, cnt: in_ch.hit_count, err: in_ch.count_error};
    raddr = i_r[AW-1:0];
    unique case (state_r)
      S_LOAD: we = in_acc && (cnt_r < CW'(MAX_ITEMS));
      // pivot address held in S_OUTER and S_PIVR so the pivot lands in S_PIVW
      S_OUTER, S_PIVR: raddr = AW'(lo_r + ((hi_r - lo_r) >>> 1));
      S_SCAN_I, S_SWP_RI: raddr = i_r[AW-1:0];
      S_SCAN_J: raddr = j_r[AW-1:0];
      S_SWP_WJ: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = tmp_r; // tmp holds item j
      end
      S_SWP_WI: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = rdata; // item i
      end
      S_EMIT_R: raddr = r_r[AW-1:0];
      default: ;
    endcase
  end

  logic [CW-1:0] n_eff, m_calc;
  always_comb begin
    n_eff = cnt_r + CW'(cnt_r < CW'(MAX_ITEMS));
    m_calc = (CW'(top_k_r) < n_eff) ? CW'(top_k_r) : n_eff;
    if (m_calc > CW'(MAX_K)) m_calc = CW'(MAX_K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      top_k_r <= TopKReset;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegTopK)
        top_k_r <= cfg_pwdata[TopKW-1:0];
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_LOAD: if (in_acc) begin
          if (!in_ch.last_item) begin
            if (cnt_r < CW'(MAX_ITEMS)) cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r <= '0;
            m_r   <= m_calc;
            r_r   <= '0;
            lo_r  <= '0;
            hi_r  <= SW'(n_eff) - SW'(1);
            tgt_r <= SW'(m_calc) - SW'(1);
            if (m_calc != '0) state_r <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (lo_r < hi_r) begin
            i_r <= lo_r; j_r <= hi_r;
            state_r <= S_PIVR;
          end else state_r <= S_EMIT_R;
        end
        S_PIVR: state_r <= S_PIVW;
        S_PIVW: begin
          piv_r <= rs;
          state_r <= (i_r <= j_r) ? S_SCAN_I : S_NEXT;
        end
        S_SCAN_I: state_r <= S_SCAN_IW;
        S_SCAN_IW: begin
          if (rs > piv_r) begin
            i_r <= i_r + SW'(1);
            state_r <= (i_r + 1 > hi_r) ? S_SCAN_J : S_SCAN_I;
          end else state_r <= S_SCAN_J;
        end
        S_SCAN_J: state_r <= S_SCAN_JW;
        S_SCAN_JW: begin
          if (rs < piv_r) begin
            j_r <= j_r - SW'(1);
            if (j_r - 1 < lo_r) state_r <= (i_r <= j_r - 1) ? S_SWP_RI : S_NEXT;
            else state_r <= S_SCAN_J;
          end else begin
            tmp_r <= rdata;
            state_r <= (i_r <= j_r) ? S_SWP_RI : S_NEXT;
          end
        end
        S_SWP_RI: state_r <= S_SWP_RIW;
        S_SWP_RIW: state_r <= S_SWP_WJ;
        S_SWP_WJ: state_r <= S_SWP_WI;
        S_SWP_WI: begin
          i_r <= i_r + SW'(1); j_r <= j_r - SW'(1);
          state_r <= (i_r + 1 <= j_r - 1) ? S_SCAN_I : S_NEXT;
        end
        S_NEXT: begin
          if (tgt_r <= j_r) begin hi_r <= j_r; state_r <= S_OUTER; end
          else if (tgt_r >= i_r) begin lo_r <= i_r; state_r <= S_OUTER; end
          else state_r <= S_EMIT_R;
        end
        S_EMIT_R: if (!ov_r || out_ch.ready) state_r <= S_EMIT_W;
        S_EMIT_W: begin
          ov_r    <= 1'b1;
          oid_r   <= rdata.id;
          ocnt_r  <= rdata.cnt;
          olast_r <= (r_r + 1'b1 == m_r);
          r_r     <= r_r + 1'b1;
          state_r <= (r_r + 1'b1 == m_r) ? S_LOAD : S_EMIT_R;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

FILE: rtl/core/tksc_checker.sv
// ---------------------------------------------------------------------------
// tksc_checker: port-level checks for the top-k select core
// Bound to the top level.
// ---------------------------------------------------------------------------
module tksc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [31:0] out_id
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_id)) else $error("out held");
  a_rdy_rst: assert property (@(posedge clk) !rst_n |=> in_ready) else $error("ready after reset");
  a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |=> !($rose(out_valid))) else $error("emit while loading");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready) else $error("early ready");
endmodule

bind top_k_select_count_minus_error_core tksc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.result_last),
  .out_id(out_ch.result_id)
);
